// ----- hdl/playfair_digram_decrypt_macros.svh -----
// Assertion macros shared by the playfair_digram_decrypt RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef PLAYFAIR_DIGRAM_DECRYPT_MACROS_SVH
`define PLAYFAIR_DIGRAM_DECRYPT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PDD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Condition that must never be true outside reset.
`define PDD_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error(msg);

`endif

// ----- hdl/pdd_pkg.sv -----
// Types, constants and lookup functions of the Playfair digram decryptor.
// No dependencies; imported by every module of the block.
package pdd_pkg;

    localparam int SIDE = 5;
    localparam int N_CELLS = SIDE * SIDE;
    localparam int CELLS_PER_WORD = 12;
    localparam int LW = 5;

    localparam logic [LW-1:0] FILLER = 5'd23;

    localparam logic [1:0] CFG_SQ_LO   = 2'd0;
    localparam logic [1:0] CFG_SQ_HI   = 2'd1;
    localparam logic [1:0] CFG_SQ_LAST = 2'd2;
    localparam logic [1:0] CFG_HIDE    = 2'd3;

    typedef logic [N_CELLS-1:0][LW-1:0] t_square;

    typedef struct packed {
        logic [LW-1:0] a0;
        logic [LW-1:0] b0;
        logic [LW-1:0] a1;
        logic          has2;
    } t_pair_item;

    typedef struct packed {
        logic       found;
        logic [2:0] row;
        logic [2:0] col;
    } t_pos;

    typedef struct packed {
        logic [1:0][LW-1:0] letter;
        logic [1:0]         nf;
        logic [1:0]         emit;
    } t_dec;

    // Last matching cell in row-major order wins.
    function automatic t_pos find_cell(input t_square sq, input logic [LW-1:0] v);
        t_pos p;
        p = '0;
        for (int r = 0; r < SIDE; r++) begin
            for (int c = 0; c < SIDE; c++) begin
                if (sq[r*SIDE+c] == v) begin
                    p.found = 1'b1;
                    p.row   = 3'(r);
                    p.col   = 3'(c);
                end
            end
        end
        return p;
    endfunction

    function automatic logic [2:0] prev5(input logic [2:0] x);
        return (x == 3'd0) ? 3'd4 : x - 3'd1;
    endfunction

    function automatic logic [LW-1:0] cell_at(input t_square sq, input logic [2:0] row,
                                              input logic [2:0] col);
        logic [4:0] idx;
        idx = {row, 2'b00} + {2'b00, row} + {2'b00, col};
        return sq[idx];
    endfunction

    function automatic t_dec decode_pair(input t_square sq, input logic hide,
                                         input logic [LW-1:0] a, input logic [LW-1:0] b,
                                         input t_pos pa, input t_pos pb);
        t_dec d;
        logic [LW-1:0] p;
        logic [LW-1:0] q;
        d = '0;
        p = '0;
        q = '0;
        if (!pa.found || !pb.found) begin
            d.letter[0] = a;
            d.letter[1] = b;
            d.nf        = 2'b11;
            d.emit      = 2'b11;
        end else begin
            if (pa.row == pb.row) begin
                p = cell_at(sq, pa.row, prev5(pa.col));
                q = cell_at(sq, pb.row, prev5(pb.col));
            end else if (pa.col == pb.col) begin
                p = cell_at(sq, prev5(pa.row), pa.col);
                q = cell_at(sq, prev5(pb.row), pb.col);
            end else begin
                p = cell_at(sq, pa.row, pb.col);
                q = cell_at(sq, pb.row, pa.col);
            end
            d.letter[0] = p;
            d.letter[1] = q;
            d.emit[0]   = !(hide && (p == FILLER));
            d.emit[1]   = !(hide && (q == FILLER));
        end
        return d;
    endfunction

endpackage

// ----- hdl/pdd_front.sv -----
// Front end: pairs incoming letters and pushes one pair item per closing letter.
// Depends on pdd_pkg.
module pdd_front import pdd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [LW-1:0] i_letter,
    input  logic          i_end_of_message,
    output logic          o_full,
    input  logic          i_q_full,
    output logic          o_q_push,
    output t_pair_item    o_q_item
);

    logic [LW-1:0] r_held_letter;
    logic          r_held_valid;
    logic [LW-1:0] n_held_letter;
    logic          n_held_valid;
    logic          accept;
    t_pair_item    item;
    logic          make;

    assign o_full = i_q_full;
    assign accept = i_push && !i_q_full;

    always_comb begin
        item          = '0;
        make          = 1'b0;
        n_held_letter = r_held_letter;
        n_held_valid  = r_held_valid;
        item.a1       = i_letter;
        if (r_held_valid) begin
            make    = 1'b1;
            item.a0 = r_held_letter;
            if (i_letter == r_held_letter) begin
                item.b0 = FILLER;
                if (i_end_of_message) begin
                    item.has2     = 1'b1;
                    n_held_valid  = 1'b0;
                    n_held_letter = '0;
                end else begin
                    n_held_letter = i_letter;
                end
            end else begin
                item.b0       = i_letter;
                n_held_valid  = 1'b0;
                n_held_letter = '0;
            end
        end else if (i_end_of_message) begin
            make    = 1'b1;
            item.a0 = i_letter;
            item.b0 = FILLER;
        end else begin
            n_held_letter = i_letter;
            n_held_valid  = 1'b1;
        end
    end

    assign o_q_push = accept && make;
    assign o_q_item = item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_letter <= '0;
            r_held_valid  <= 1'b0;
        end else if (accept) begin
            r_held_letter <= n_held_letter;
            r_held_valid  <= n_held_valid;
        end
    end

endmodule

// ----- hdl/pdd_fifo.sv -----
// Short register queue of pair items between the front and back ends.
// Depends on pdd_pkg.
module pdd_fifo import pdd_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_pair_item i_item,
    output logic       o_full,
    input  logic       i_pop,
    output t_pair_item o_item,
    output logic       o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_pair_item    r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= wrap_inc(r_wr);
            end
            if (do_pop) begin
                r_rd <= wrap_inc(r_rd);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// ----- hdl/pdd_back.sv -----
// Back end: square lookup stage, pair resolve stage, result emitter, output register.
// Depends on pdd_pkg and playfair_digram_decrypt_macros.svh.
`include "playfair_digram_decrypt_macros.svh"
module pdd_back import pdd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_square       i_square,
    input  logic          i_hide,
    input  logic          i_q_empty,
    input  t_pair_item    i_q_item,
    output logic          o_q_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [LW-1:0] o_plain_letter,
    output logic          o_not_found,
    output logic          o_last
);

    // Lookup stage.
    logic       r_l_v;
    t_pair_item r_l_item;
    t_pos       r_l_pa0;
    t_pos       r_l_pb0;
    t_pos       r_l_pa1;
    t_pos       r_l_px;

    // Resolve stage, also the emitter.
    logic                 r_r_v;
    logic [3:0]           r_r_mask;
    logic [3:0][LW-1:0]   r_r_letter;
    logic [3:0]           r_r_nf;

    // Output register.
    logic          r_out_v;
    logic [LW-1:0] r_out_letter;
    logic          r_out_nf;
    logic          r_out_last;

    logic          out_load;
    logic          emit;
    logic [3:0]    low;
    logic [3:0]    rest;
    logic          r_free;
    logic          l_adv;
    logic          l_free;
    logic [LW-1:0] e_letter;
    logic          e_nf;
    t_dec          dec0;
    t_dec          dec1;
    logic [3:0]    n_mask;

    assign out_load = !r_out_v || i_pop;
    assign emit     = r_r_v && out_load;
    assign low      = r_r_mask & (~r_r_mask + 4'd1);
    assign rest     = r_r_mask & ~low;
    assign r_free   = !r_r_v || (emit && (rest == '0));
    assign l_adv    = r_l_v && r_free;
    assign l_free   = !r_l_v || r_free;
    assign o_q_pop  = !i_q_empty && l_free;

    always_comb begin
        e_letter = '0;
        e_nf     = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (low[i]) begin
                e_letter = r_r_letter[i];
                e_nf     = r_r_nf[i];
            end
        end
    end

    assign dec0   = decode_pair(i_square, i_hide, r_l_item.a0, r_l_item.b0, r_l_pa0, r_l_pb0);
    assign dec1   = decode_pair(i_square, i_hide, r_l_item.a1, FILLER, r_l_pa1, r_l_px);
    assign n_mask = {(r_l_item.has2 ? dec1.emit : 2'b00), dec0.emit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_v    <= 1'b0;
            r_r_v    <= 1'b0;
            r_r_mask <= '0;
            r_out_v  <= 1'b0;
        end else begin
            if (l_free) begin
                r_l_v <= !i_q_empty;
            end
            if (r_free) begin
                r_r_v    <= l_adv && (n_mask != '0);
                r_r_mask <= l_adv ? n_mask : 4'b0000;
            end else if (emit) begin
                r_r_mask <= rest;
            end
            if (out_load) begin
                r_out_v <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_l_item <= i_q_item;
            r_l_pa0  <= find_cell(i_square, i_q_item.a0);
            r_l_pb0  <= find_cell(i_square, i_q_item.b0);
            r_l_pa1  <= find_cell(i_square, i_q_item.a1);
            r_l_px   <= find_cell(i_square, FILLER);
        end
        if (l_adv) begin
            r_r_letter <= {dec1.letter[1], dec1.letter[0], dec0.letter[1], dec0.letter[0]};
            r_r_nf     <= {dec1.nf, dec0.nf};
        end
        if (emit) begin
            r_out_letter <= e_letter;
            r_out_nf     <= e_nf;
            r_out_last   <= (rest == '0);
        end
    end

    assign o_empty        = !r_out_v;
    assign o_plain_letter = r_out_letter;
    assign o_not_found    = r_out_nf;
    assign o_last         = r_out_last;

    `PDD_NEVER(a_live_mask, i_clk, i_rst_n, r_r_v && (r_r_mask == '0), "empty result mask")
    `PDD_ASSERT(a_more_follow, i_clk, i_rst_n, (emit && (rest != '0)) |=> r_r_v, "results lost")
    `PDD_ASSERT(a_lookup_hold, i_clk, i_rst_n, (r_l_v && !r_free) |=> (r_l_v && $stable(r_l_item)), "lookup stage overrun")

endmodule

// ----- hdl/playfair_digram_decrypt.sv -----
// Playfair digram decryptor top level: configuration registers and the front/back pipeline.
// Depends on pdd_pkg, pdd_front, pdd_fifo and pdd_back.
//
// Usage: ciphertext letters enter through a queue-style port: a transfer happens on an
// edge with i_push high and o_full low. Letters pair up; a pair that closes produces up
// to two plaintext letters, and a repeated letter flagged end of message up to four.
// Results leave through a queue-style port: the oldest result sits on the output ports
// while o_empty is low and is transferred on an edge with i_pop high.
// The key square and the filler-hide flag are written through the configuration channel
// (i_cfg_valid with o_cfg_ready, always high); the user must write them only while the
// block is idle, and the block itself does not enforce this. A pair's results pass the
// pair queue, the lookup stage, the resolve stage and the output register in that order.
// Throughput: one letter is taken every cycle while o_full is low and one result leaves
// every cycle while i_pop is high; the emitter, sending one result per cycle unless the
// output stalls, sets the sustained rate; an input with k results holds it for all k.
// Reset clears the held letter, the queue and all pipeline stages; the square resets
// to all zero and filler hiding to on. When the receiver stalls, the output register
// holds, the stages fill and o_full rises once the pair queue is full.
module playfair_digram_decrypt import pdd_pkg::*; #(
    parameter int P_QUEUE_DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [4:0]    i_letter,
    input  logic          i_end_of_message,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [4:0]    o_plain_letter,
    output logic          o_not_found,
    output logic          o_last,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [59:0]   i_cfg_data
);

    t_square    r_square;
    logic       r_hide;
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_empty;
    t_pair_item q_in;
    t_pair_item q_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_square <= '0;
            r_hide   <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SQ_LO: begin
                    for (int i = 0; i < CELLS_PER_WORD; i++) begin
                        r_square[i] <= i_cfg_data[LW*i +: LW];
                    end
                end
                CFG_SQ_HI: begin
                    for (int i = 0; i < CELLS_PER_WORD; i++) begin
                        r_square[CELLS_PER_WORD+i] <= i_cfg_data[LW*i +: LW];
                    end
                end
                CFG_SQ_LAST: begin
                    r_square[N_CELLS-1] <= i_cfg_data[LW-1:0];
                end
                CFG_HIDE: begin
                    r_hide <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    pdd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (i_push),
        .i_letter         (i_letter),
        .i_end_of_message (i_end_of_message),
        .o_full           (o_full),
        .i_q_full         (q_full),
        .o_q_push         (q_push),
        .o_q_item         (q_in)
    );

    pdd_fifo #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_out),
        .o_empty (q_empty)
    );

    pdd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_square       (r_square),
        .i_hide         (r_hide),
        .i_q_empty      (q_empty),
        .i_q_item       (q_out),
        .o_q_pop        (q_pop),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_plain_letter (o_plain_letter),
        .o_not_found    (o_not_found),
        .o_last         (o_last)
    );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for playfair_digram_decrypt: directed rows, then random messages.
// Depends on pdd_pkg for the register indexes and the filler letter; needs only the RTL.
// A built-in Playfair decoder predicts the non-reset-square results; each pop is checked.
module testbench;

    localparam logic [4:0] FILLER_LETTER = pdd_pkg::FILLER;
    localparam int N_DIRECTED = 25;
    localparam int N_RANDOM_PHASES = 8;
    localparam int LETTERS_PER_PHASE = 16;
    localparam int CLASSIC_KEY [25] = '{15, 11, 0, 24, 5, 8, 17, 4, 23, 12, 1, 2, 3, 6, 7,
                                        10, 13, 14, 16, 18, 19, 20, 21, 22, 25};

    typedef enum int {SQ_CLASSIC, SQ_PERM, SQ_DUPS, SQ_NARROW, SQ_ONES, SQ_ZERO} t_square_kind;

    typedef struct packed {
        logic [4:0] plain;
        logic       not_found;
        logic       last;
    } t_plain;

    typedef struct packed {
        logic [1:0]        phase;
        logic [4:0]        letter;
        logic              eom;
        logic signed [3:0] n_typed;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_push;
    logic        o_full;
    logic [4:0]  i_letter;
    logic        i_end_of_message;
    logic        o_empty;
    logic        i_pop = 1'b1;
    logic [4:0]  o_plain_letter;
    logic        o_not_found;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [59:0] i_cfg_data;

    logic [4:0] key_model [25];
    logic       hide_model;
    logic [4:0] held_model;
    logic       held_model_valid;
    logic [4:0] key_cells [25];

    t_plain    plain_expected [$];
    t_plain    step_out [$];
    t_stim_row dir_rows [N_DIRECTED];

    int typed_n = -1;
    int errors = 0;
    int letters_in = 0;
    int results_seen = 0;
    int reg_writes = 0;
    int burst_left = 0;
    int pop_run = 0;
    bit stall_on = 1'b1;
    bit gaps_on = 1'b1;

    playfair_digram_decrypt i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (i_push),
        .o_full           (o_full),
        .i_letter         (i_letter),
        .i_end_of_message (i_end_of_message),
        .o_empty          (o_empty),
        .i_pop            (i_pop),
        .o_plain_letter   (o_plain_letter),
        .o_not_found      (o_not_found),
        .o_last           (o_last),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("%0t: timeout with %0d results outstanding", $time, plain_expected.size());
        $display("** playfair_digram_decrypt: FAILED **");
        $finish;
    end

    // Later cells win when a letter appears more than once.
    function automatic logic locate(input logic [4:0] v, output int row, output int col);
        logic hit;
        hit = 1'b0;
        row = 0;
        col = 0;
        for (int i = 0; i < 25; i++) begin
            if (key_model[i] == v) begin
                row = i / 5;
                col = i % 5;
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic void add_plain(input logic [4:0] v, input logic nf);
        t_plain r;
        r.plain = v;
        r.not_found = nf;
        r.last = 1'b0;
        step_out.push_back(r);
    endfunction

    function automatic void decrypt_digram(input logic [4:0] a, input logic [4:0] b);
        int r1, c1, r2, c2;
        logic fa, fb;
        logic [4:0] p, q;
        fa = locate(a, r1, c1);
        fb = locate(b, r2, c2);
        if (!fa || !fb) begin
            add_plain(a, 1'b1);
            add_plain(b, 1'b1);
        end else begin
            if (r1 == r2) begin
                p = key_model[r1 * 5 + (c1 + 4) % 5];
                q = key_model[r2 * 5 + (c2 + 4) % 5];
            end else if (c1 == c2) begin
                p = key_model[((r1 + 4) % 5) * 5 + c1];
                q = key_model[((r2 + 4) % 5) * 5 + c2];
            end else begin
                p = key_model[r1 * 5 + c2];
                q = key_model[r2 * 5 + c1];
            end
            if (!(hide_model && p == FILLER_LETTER)) add_plain(p, 1'b0);
            if (!(hide_model && q == FILLER_LETTER)) add_plain(q, 1'b0);
        end
    endfunction

    function automatic void decrypt_letter(input logic [4:0] letter, input logic eom);
        t_plain t;
        step_out.delete();
        if (held_model_valid) begin
            if (letter == held_model) begin
                decrypt_digram(held_model, FILLER_LETTER);
                if (eom) begin
                    decrypt_digram(letter, FILLER_LETTER);
                    held_model_valid = 1'b0;
                    held_model = '0;
                end
            end else begin
                decrypt_digram(held_model, letter);
                held_model_valid = 1'b0;
                held_model = '0;
            end
        end else if (eom) begin
            decrypt_digram(letter, FILLER_LETTER);
        end else begin
            held_model = letter;
            held_model_valid = 1'b1;
        end
        if (step_out.size() > 0) begin
            t = step_out.pop_back();
            t.last = 1'b1;
            step_out.push_back(t);
        end
    endfunction

    function automatic void apply_config(input logic [1:0] idx, input logic [59:0] data);
        if (idx == pdd_pkg::CFG_SQ_LO) begin
            for (int i = 0; i < 12; i++) key_model[i] = data[5 * i +: 5];
        end else if (idx == pdd_pkg::CFG_SQ_HI) begin
            for (int i = 0; i < 12; i++) key_model[12 + i] = data[5 * i +: 5];
        end else if (idx == pdd_pkg::CFG_SQ_LAST) begin
            key_model[24] = data[4:0];
        end else begin
            hide_model = data[0];
        end
    endfunction

    function automatic t_stim_row dir_row(input int phase, input int letter, input int eom,
                                          input int n_typed);
        t_stim_row r;
        r.phase = phase[1:0];
        r.letter = letter[4:0];
        r.eom = eom[0];
        r.n_typed = n_typed[3:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_plain want;
        t_plain t;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                apply_config(i_cfg_index, i_cfg_data);
                reg_writes++;
            end
            if (i_push && !o_full) begin
                letters_in++;
                decrypt_letter(i_letter, i_end_of_message);
                if (typed_n >= 0) begin
                    // Against the all-zero square every pair misses, so each pair echoes
                    // the letter and then the filler.
                    for (int k = 0; k < typed_n; k++) begin
                        t.plain = (k % 2 == 0) ? i_letter : FILLER_LETTER;
                        t.not_found = 1'b1;
                        t.last = (k == typed_n - 1);
                        plain_expected.push_back(t);
                    end
                end else begin
                    foreach (step_out[k]) plain_expected.push_back(step_out[k]);
                end
            end
            if (i_pop && !o_empty) begin
                results_seen++;
                if (plain_expected.size() == 0) begin
                    $display("%0t: unexpected result plain_letter=%0d not_found=%0b last=%0b",
                             $time, o_plain_letter, o_not_found, o_last);
                    errors++;
                end else begin
                    want = plain_expected.pop_front();
                    if (o_plain_letter !== want.plain) begin
                        $display("%0t: plain_letter expected %0d, got %0d",
                                 $time, want.plain, o_plain_letter);
                        errors++;
                    end
                    if (o_not_found !== want.not_found) begin
                        $display("%0t: not_found expected %0b, got %0b",
                                 $time, want.not_found, o_not_found);
                        errors++;
                    end
                    if (o_last !== want.last) begin
                        $display("%0t: last expected %0b, got %0b", $time, want.last, o_last);
                        errors++;
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        logic pop_next;
        if (pop_run > 0) begin
            pop_run--;
        end else begin
            pop_next = stall_on ? ($urandom_range(0, 2) != 0) : 1'b1;
            pop_run = pop_next ? $urandom_range(1, 10) : $urandom_range(1, 12);
            i_pop <= pop_next;
        end
    end

    task automatic send_item(input logic [4:0] letter, input logic eom);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                i_push = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_push = 1'b1;
        i_letter = letter;
        i_end_of_message = eom;
        do @(posedge i_clk); while (o_full);
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_push = 1'b0;
        while (plain_expected.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [59:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic fill_square(input t_square_kind kind);
        logic [4:0] pool [26];
        logic [4:0] t;
        int j;
        for (int i = 0; i < 26; i++) pool[i] = i[4:0];
        for (int i = 25; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = pool[i];
            pool[i] = pool[j];
            pool[j] = t;
        end
        for (int i = 0; i < 25; i++) begin
            case (kind)
                SQ_CLASSIC: key_cells[i] = CLASSIC_KEY[i][4:0];
                SQ_PERM:    key_cells[i] = pool[i];
                SQ_DUPS:    key_cells[i] = 5'($urandom_range(0, 31));
                SQ_NARROW:  key_cells[i] = 5'($urandom_range(0, 7));
                SQ_ONES:    key_cells[i] = (i == 24) ? 5'd25 : 5'd31;
                default:    key_cells[i] = 5'd0;
            endcase
        end
    endtask

    task automatic load_square(input logic hide);
        logic [59:0] lo, hi;
        for (int i = 0; i < 12; i++) begin
            lo[5 * i +: 5] = key_cells[i];
            hi[5 * i +: 5] = key_cells[12 + i];
        end
        write_reg(pdd_pkg::CFG_SQ_LO, lo);
        write_reg(pdd_pkg::CFG_SQ_HI, hi);
        write_reg(pdd_pkg::CFG_SQ_LAST, {55'd0, key_cells[24]});
        write_reg(pdd_pkg::CFG_HIDE, {59'd0, hide});
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        int cur_phase;
        int sent;
        int len;
        int pick;
        logic [4:0] l;
        logic [4:0] prev;
        logic hide;
        t_square_kind kind;

        for (int i = 0; i < 25; i++) key_model[i] = '0;
        hide_model = 1'b1;
        held_model = '0;
        held_model_valid = 1'b0;
        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_letter = '0;
        i_end_of_message = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;

        // Reset square: every pair misses.
        dir_rows[0]  = dir_row(0, 0, 1, 2);
        dir_rows[1]  = dir_row(0, 31, 1, 2);
        dir_rows[2]  = dir_row(0, 7, 0, 0);
        dir_rows[3]  = dir_row(0, 7, 1, 4);
        dir_rows[4]  = dir_row(0, 0, 0, 0);
        dir_rows[5]  = dir_row(0, 0, 0, 2);
        dir_rows[6]  = dir_row(0, 0, 1, 4);
        // Classic square with filler hiding: row, column, rectangle, dropped filler,
        // a filler pair, repeats at end of message and a letter missing from the square.
        dir_rows[7]  = dir_row(1, 15, 0, -1);
        dir_rows[8]  = dir_row(1, 0, 0, -1);
        dir_rows[9]  = dir_row(1, 8, 0, -1);
        dir_rows[10] = dir_row(1, 1, 0, -1);
        dir_rows[11] = dir_row(1, 15, 0, -1);
        dir_rows[12] = dir_row(1, 25, 0, -1);
        dir_rows[13] = dir_row(1, 8, 0, -1);
        dir_rows[14] = dir_row(1, 12, 0, -1);
        dir_rows[15] = dir_row(1, 23, 0, -1);
        dir_rows[16] = dir_row(1, 23, 0, -1);
        dir_rows[17] = dir_row(1, 23, 1, -1);
        dir_rows[18] = dir_row(1, 9, 0, -1);
        dir_rows[19] = dir_row(1, 0, 0, -1);
        dir_rows[20] = dir_row(1, 16, 0, -1);
        dir_rows[21] = dir_row(1, 16, 1, -1);
        // Same square with the filler shown.
        dir_rows[22] = dir_row(2, 8, 0, -1);
        dir_rows[23] = dir_row(2, 12, 0, -1);
        dir_rows[24] = dir_row(2, 5, 1, -1);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        cur_phase = 0;
        for (int i = 0; i < N_DIRECTED; i++) begin
            if (dir_rows[i].phase != cur_phase) begin
                settle();
                cur_phase = dir_rows[i].phase;
                fill_square(SQ_CLASSIC);
                load_square(cur_phase == 1);
            end
            typed_n = dir_rows[i].n_typed;
            send_item(dir_rows[i].letter, dir_rows[i].eom);
        end
        settle();
        typed_n = -1;

        for (int p = 0; p < N_RANDOM_PHASES; p++) begin
            case (p)
                0: begin kind = SQ_PERM;   hide = 1'b1; end
                1: begin kind = SQ_PERM;   hide = 1'b0; end
                2: begin kind = SQ_DUPS;   hide = 1'($urandom_range(0, 1)); end
                3: begin kind = SQ_ONES;   hide = 1'b1; end
                4: begin kind = SQ_NARROW; hide = 1'b1; end
                5: begin kind = SQ_ZERO;   hide = 1'b0; end
                6: begin kind = SQ_DUPS;   hide = 1'($urandom_range(0, 1)); end
                default: begin kind = SQ_PERM; hide = 1'($urandom_range(0, 1)); end
            endcase
            stall_on = (p % 3 != 2);
            gaps_on = (p % 4 != 3);
            fill_square(kind);
            load_square(hide);
            sent = 0;
            while (sent < LETTERS_PER_PHASE) begin
                if ($urandom_range(0, 9) < 8) begin
                    // Well-formed message mostly drawn from the square, with occasional repeats and random letters.
                    len = $urandom_range(1, 10);
                    prev = key_cells[$urandom_range(0, 24)];
                    for (int k = 0; k < len; k++) begin
                        pick = $urandom_range(0, 19);
                        if (pick < 3 && k > 0) l = prev;
                        else if (pick == 3) l = 5'($urandom_range(0, 31));
                        else l = key_cells[$urandom_range(0, 24)];
                        send_item(l, k == len - 1);
                        prev = l;
                        sent++;
                    end
                end else begin
                    send_item(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
                    sent++;
                end
            end
            settle();
        end

        $display("Sent %0d letters over %0d key squares with %0d register writes;",
                 letters_in, N_RANDOM_PHASES + 3, reg_writes);
        $display("checked %0d decrypted letters, %0d mismatches.", results_seen, errors);
        if (errors == 0) begin
            $display("** playfair_digram_decrypt: PASSED **");
        end else begin
            $display("** playfair_digram_decrypt: FAILED **");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/pdd_pkg.sv
hdl/pdd_front.sv
hdl/pdd_fifo.sv
hdl/pdd_back.sv
hdl/playfair_digram_decrypt.sv
tb/testbench.sv
